### rtl/ghal_pkg.sv
// ----------------------------------------------------------------------------
// ghal_pkg
// shared types and codes of the generational handle allocator
// ----------------------------------------------------------------------------
package ghal_pkg;

    // fixed handle layout: index in the low bits, generation above it
    localparam int HANDLE_W    = 32;
    localparam int HIDX_W      = 19;
    localparam int HGEN_W      = 13;
    localparam int LIVE_W      = 11;
    localparam int CMP_W       = 20;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CHECK   = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                is_valid;
        logic [1:0]          status;
        logic [LIVE_W-1:0]   live_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_needed;
        logic rsp_free;
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

endpackage

### rtl/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// hands out generational handles from a lifo free stack of slots or fresh slots
// ----------------------------------------------------------------------------
// idle accepts a transaction and the emit state writes its response;
//   an allocate that pops the free stack passes the pop state in between
//   (stack read, then dependent generation read)
// the single-issue sequencer takes no new request until the last is emitted
// reset: counters and response valid clear at once, memories are not
//   cleared and need no sweep; requests are taken right after reset
// ----------------------------------------------------------------------------
module generational_handle_allocator_top #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ghal_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ghal_pkg::rsp_t rsp
);

    // command and status between sequencer and datapath
    ghal_pkg::cmd_t  cmd;
    ghal_pkg::stat_t stat;

    // sequencer: idle accepts a transaction, pop state takes the free stack
    // top and reads its generation, emit state waits for room in the response register
    ghal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: free depth, high-water mark, live count, the two memories
    // and the response register, which decouples the output side
    ghal_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### rtl/ghal_ram.sv
// ----------------------------------------------------------------------------
// ghal_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ghal_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ghal_ctrl.sv
// ----------------------------------------------------------------------------
// ghal_ctrl
// sequencing state machine: accept, optional stack pop, emit
// ----------------------------------------------------------------------------
module ghal_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ghal_pkg::stat_t stat,
    output ghal_pkg::cmd_t  cmd
);

    ghal_pkg::state_t state_reg;
    ghal_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ghal_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.pop_needed ? ghal_pkg::S_POP : ghal_pkg::S_EMIT;
                end
            end
            ghal_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ghal_pkg::S_EMIT;
            end
            ghal_pkg::S_EMIT:
            begin
                // hold until the response register can take the transaction
                if (stat.rsp_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ghal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ghal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ghal_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ghal_datapath.sv
// ----------------------------------------------------------------------------
// ghal_datapath
// counters, generation and free-stack memories, response register
// ----------------------------------------------------------------------------
module ghal_datapath #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 13
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ghal_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ghal_pkg::rsp_t  rsp,
    input  ghal_pkg::cmd_t  cmd,
    output ghal_pkg::stat_t stat
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

    logic [CW-1:0] fd_reg, fd_next;
    logic [CW-1:0] hw_reg, hw_next;
    logic [CW-1:0] live_reg, live_next;
    logic          rsp_valid_reg, rsp_valid_next;
    ghal_pkg::rsp_t rsp_reg, rsp_next;

    // per-transaction registers
    logic [1:0]                  mode_reg;
    logic [ghal_pkg::HGEN_W-1:0] hgen_reg;
    logic [IW-1:0]               idx_reg;
    logic                        popped_reg;
    logic                        in_range_reg;

    // memories
    logic                gen_we;
    logic [IW-1:0]       gen_waddr;
    logic [GEN_BITS-1:0] gen_wdata;
    logic                gen_re;
    logic [IW-1:0]       gen_raddr;
    logic [GEN_BITS-1:0] gen_rdata;
    logic                stk_we;
    logic [IW-1:0]       stk_raddr;
    logic [IW-1:0]       stk_rdata;

    logic [ghal_pkg::HIDX_W-1:0] req_idx;
    logic                        req_in_range;
    logic                        gen_match;
    logic                        handle_ok;
    logic                        release_ok;
    logic                        fresh_ok;
    logic [GEN_BITS-1:0]         gen_bumped;
    logic [CW-1:0]               fd_dec;

    assign req_idx      = req.handle_in[ghal_pkg::HIDX_W-1:0];
    assign req_in_range = ghal_pkg::CMP_W'(req_idx) < ghal_pkg::CMP_W'(hw_reg);
    assign fd_dec       = fd_reg - CW'(1);

    assign stat.pop_needed = (req.mode == ghal_pkg::MODE_ALLOC) && (fd_reg != '0);
    assign stat.rsp_free   = !rsp_valid_reg || rsp_ready;

    assign stk_raddr = fd_dec[IW-1:0];
    assign gen_re    = cmd.load || cmd.pop;
    assign gen_raddr = cmd.pop ? stk_rdata : req_idx[IW-1:0];

    assign gen_match  = ghal_pkg::HGEN_W'(gen_rdata) == hgen_reg;
    assign handle_ok  = in_range_reg && gen_match;
    assign release_ok = handle_ok && (live_reg != '0) && (fd_reg < SLOTS);
    assign fresh_ok   = hw_reg < SLOTS;
    assign gen_bumped = (gen_rdata == '1) ? GEN_BITS'(1) : gen_rdata + GEN_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= req.mode;
            hgen_reg     <= req.handle_in[ghal_pkg::HANDLE_W-1:ghal_pkg::HIDX_W];
            idx_reg      <= req_idx[IW-1:0];
            popped_reg   <= stat.pop_needed;
            in_range_reg <= req_in_range;
        end
        if (cmd.pop)
        begin
            idx_reg <= stk_rdata;
        end
    end

    always_comb
    begin
        fd_next        = fd_reg;
        hw_next        = hw_reg;
        live_next      = live_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        gen_we         = 1'b0;
        gen_waddr      = idx_reg;
        gen_wdata      = gen_bumped;
        stk_we         = 1'b0;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            case (mode_reg)
                ghal_pkg::MODE_ALLOC:
                begin
                    if (popped_reg)
                    begin
                        fd_next             = fd_dec;
                        live_next           = live_reg + CW'(1);
                        rsp_next.handle_out = {ghal_pkg::HGEN_W'(gen_rdata),
                                               ghal_pkg::HIDX_W'(idx_reg)};
                    end
                    else if (fresh_ok)
                    begin
                        gen_we              = 1'b1;
                        gen_waddr           = hw_reg[IW-1:0];
                        gen_wdata           = GEN_BITS'(1);
                        hw_next             = hw_reg + CW'(1);
                        live_next           = live_reg + CW'(1);
                        rsp_next.handle_out = {ghal_pkg::HGEN_W'(1),
                                               ghal_pkg::HIDX_W'(hw_reg[IW-1:0])};
                    end
                    else
                    begin
                        rsp_next.status = ghal_pkg::STATUS_FULL;
                    end
                end
                ghal_pkg::MODE_RELEASE:
                begin
                    if (release_ok)
                    begin
                        gen_we    = 1'b1;
                        stk_we    = 1'b1;
                        fd_next   = fd_reg + CW'(1);
                        live_next = live_reg - CW'(1);
                    end
                    else
                    begin
                        rsp_next.status = ghal_pkg::STATUS_BAD_FREE;
                    end
                end
                ghal_pkg::MODE_CHECK:
                begin
                    rsp_next.is_valid = handle_ok;
                end
                default:
                begin
                    // clear free depth, high-water mark and live count
                    fd_next   = '0;
                    hw_next   = '0;
                    live_next = '0;
                end
            endcase
            rsp_next.live_count = ghal_pkg::LIVE_W'(live_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg        <= '0;
            hw_reg        <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fd_reg        <= fd_next;
            hw_reg        <= hw_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ghal_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    ghal_ram #(
        .WIDTH (IW),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (fd_reg[IW-1:0]),
        .wdata (idx_reg),
        .re    (cmd.load),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the generational handle allocator: a queue-fed
// driver, a monitor that checks every response against an in-bench allocator
// model, random idling on both channels and a table fill
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = 1024;
    localparam int GEN_BITS    = 13;
    localparam int GEN_LIMIT   = 1 << GEN_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STALE_KEEP  = 32;
    localparam int RAND_PER_PHASE = 80;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request and response channels
    logic           req_valid = 1'b0;
    logic           req_ready;
    ghal_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    ghal_pkg::rsp_t rsp;

    // idling knobs, percent of cycles spent idle on each side
    int send_idle = 0;
    int recv_idle = 0;

    int cycle_count = 0;
    int fail_count  = 0;

    // requests waiting for the driver, responses waiting for the monitor
    ghal_pkg::req_t request_q[$];
    ghal_pkg::rsp_t predicted_rsp_q[$];
    ghal_pkg::rsp_t want;

    // allocator model state
    logic [ghal_pkg::HGEN_W-1:0] slot_gen[SLOT_COUNT];
    int                          free_slots[SLOT_COUNT];
    int                          free_depth = 0;
    int                          high_water = 0;
    int                          live_total = 0;

    // handles the model considers live, and recently retired ones, for stimulus
    logic [ghal_pkg::HANDLE_W-1:0] live_handles[$];
    logic [ghal_pkg::HANDLE_W-1:0] retired_handles[$];

    generational_handle_allocator_top #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // generation after a release, skipping zero on wrap
    function automatic logic [ghal_pkg::HGEN_W-1:0] next_gen(
        logic [ghal_pkg::HGEN_W-1:0] g);
        if (int'(g) + 1 >= GEN_LIMIT)
            return ghal_pkg::HGEN_W'(1);
        return g + 1'b1;
    endfunction

    // a handle is current when its index is in use range and its generation matches
    function automatic logic handle_current(logic [ghal_pkg::HANDLE_W-1:0] h);
        int idx;
        idx = int'(h[ghal_pkg::HIDX_W-1:0]);
        if (idx >= high_water || idx >= SLOT_COUNT)
            return 1'b0;
        return slot_gen[idx] == h[ghal_pkg::HANDLE_W-1:ghal_pkg::HIDX_W];
    endfunction

    // advance the allocator model by one request and give its response
    function automatic ghal_pkg::rsp_t apply_request(ghal_pkg::req_t r);
        ghal_pkg::rsp_t o;
        int             slot;
        logic           got;
        o   = '0;
        got = 1'b1;
        slot = 0;
        case (r.mode)
            ghal_pkg::MODE_ALLOC:
            begin
                if (free_depth > 0)
                begin
                    // most recently released slot first
                    free_depth--;
                    slot = free_slots[free_depth];
                end
                else if (high_water < SLOT_COUNT)
                begin
                    // fresh slot starts at generation one
                    slot = high_water;
                    slot_gen[slot] = ghal_pkg::HGEN_W'(1);
                    high_water++;
                end
                else
                begin
                    got = 1'b0;
                end
                if (got)
                begin
                    live_total++;
                    o.handle_out = {slot_gen[slot], ghal_pkg::HIDX_W'(slot)};
                    live_handles.insert(live_handles.size(), o.handle_out);
                end
                else
                begin
                    o.status = ghal_pkg::STATUS_FULL;
                end
            end
            ghal_pkg::MODE_RELEASE:
            begin
                if (handle_current(r.handle_in) && live_total > 0 &&
                    free_depth < SLOT_COUNT)
                begin
                    slot = int'(r.handle_in[ghal_pkg::HIDX_W-1:0]);
                    slot_gen[slot] = next_gen(slot_gen[slot]);
                    free_slots[free_depth] = slot;
                    free_depth++;
                    live_total--;
                    for (int i = 0; i < live_handles.size(); i++)
                    begin
                        if (live_handles[i] == r.handle_in)
                        begin
                            live_handles.delete(i);
                            break;
                        end
                    end
                    retired_handles.insert(retired_handles.size(), r.handle_in);
                    if (retired_handles.size() > STALE_KEEP)
                        void'(retired_handles.pop_front());
                end
                else
                begin
                    o.status = ghal_pkg::STATUS_BAD_FREE;
                end
            end
            ghal_pkg::MODE_CHECK:
            begin
                o.is_valid = handle_current(r.handle_in);
            end
            default:
            begin
                free_depth = 0;
                high_water = 0;
                live_total = 0;
                live_handles.delete();
            end
        endcase
        o.live_count = ghal_pkg::LIVE_W'(live_total);
        return o;
    endfunction

    // driver: present the next pending request, hold it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            // predict at the edge that accepts the transaction
            if (req_valid && req_ready)
                predicted_rsp_q.insert(predicted_rsp_q.size(), apply_request(req));
            // free to move on unless a transaction is still waiting for ready
            if (!(req_valid && !req_ready))
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    req       <= request_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, check every accepted response in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_rsp_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display({"mismatch: response with nothing expected: ",
                                  "handle_out %h is_valid %b status %0d live_count %0d"},
                                 rsp.handle_out, rsp.is_valid, rsp.status, rsp.live_count);
                    fail_count++;
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    if (rsp.handle_out !== want.handle_out ||
                        rsp.is_valid !== want.is_valid ||
                        rsp.status !== want.status ||
                        rsp.live_count !== want.live_count)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch at cycle %0d:", cycle_count);
                            $display({"  expected handle_out %h is_valid %b ",
                                      "status %0d live_count %0d"},
                                     want.handle_out, want.is_valid, want.status,
                                     want.live_count);
                            $display({"  actual   handle_out %h is_valid %b ",
                                      "status %0d live_count %0d"},
                                     rsp.handle_out, rsp.is_valid, rsp.status,
                                     rsp.live_count);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // queue one request, keeping the queue shallow so stimulus tracks the model
    task automatic send(logic [1:0] mode, logic [ghal_pkg::HANDLE_W-1:0] h);
        ghal_pkg::req_t r;
        r.mode      = mode;
        r.handle_in = h;
        while (request_q.size() >= 2)
            @(negedge clk);
        request_q.insert(request_q.size(), r);
    endtask

    // wait until every queued transaction has been answered
    task automatic drain();
        while (request_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    // arbitrary handle: fully random, or a small index with a random generation
    function automatic logic [ghal_pkg::HANDLE_W-1:0] any_handle();
        if ($urandom_range(1) == 0)
            return $urandom;
        return {ghal_pkg::HGEN_W'($urandom), 9'd0, 10'($urandom)};
    endfunction

    function automatic logic [ghal_pkg::HANDLE_W-1:0] pick_live();
        if (live_handles.size() == 0)
            return any_handle();
        return live_handles[$urandom_range(live_handles.size() - 1)];
    endfunction

    function automatic logic [ghal_pkg::HANDLE_W-1:0] pick_retired();
        if (retired_handles.size() == 0)
            return any_handle();
        return retired_handles[$urandom_range(retired_handles.size() - 1)];
    endfunction

    // random traffic, mostly well-formed: allocs, releases of live handles, checks, rare clears
    task automatic run_random(int count);
        int                            pick;
        int                            src;
        logic [ghal_pkg::HANDLE_W-1:0] h;
        repeat (count)
        begin
            pick = $urandom_range(99);
            src  = $urandom_range(99);
            if (pick < 38)
            begin
                send(ghal_pkg::MODE_ALLOC, $urandom);
            end
            else if (pick < 66)
            begin
                // release: live, retired, retired one generation on, or noise
                if (src < 70)
                    h = pick_live();
                else if (src < 80)
                    h = pick_retired();
                else if (src < 88)
                begin
                    h = pick_retired();
                    h[ghal_pkg::HANDLE_W-1:ghal_pkg::HIDX_W] =
                        next_gen(h[ghal_pkg::HANDLE_W-1:ghal_pkg::HIDX_W]);
                end
                else
                    h = any_handle();
                send(ghal_pkg::MODE_RELEASE, h);
            end
            else if (pick < 97)
            begin
                // check: live, retired, wrong generation, index out of range, noise
                h = pick_live();
                if (src < 45)
                    ;
                else if (src < 65)
                    h = pick_retired();
                else if (src < 75)
                    h[ghal_pkg::HIDX_W + $urandom_range(ghal_pkg::HGEN_W - 1)] ^= 1'b1;
                else if (src < 85)
                    h[ghal_pkg::HIDX_W - 1 - $urandom_range(8)] = 1'b1;
                else
                    h = any_handle();
                send(ghal_pkg::MODE_CHECK, h);
            end
            else
            begin
                send(ghal_pkg::MODE_CLEAR, $urandom);
            end
        end
    endtask

    initial
    begin
        // reset held low from the start, released at a rising edge
        send_idle = 16;
        recv_idle = 68;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, live count zero, double release, clear
        send(ghal_pkg::MODE_CHECK,   32'h0000_0000);   // nothing allocated yet
        send(ghal_pkg::MODE_RELEASE, 32'h0008_0000);   // release with nothing live
        send(ghal_pkg::MODE_ALLOC,   32'h0000_0000);   // fresh slot 0, generation 1
        send(ghal_pkg::MODE_ALLOC,   32'hFFFF_FFFF);   // fresh slot 1
        send(ghal_pkg::MODE_CHECK,   32'h0008_0000);   // current
        send(ghal_pkg::MODE_CHECK,   32'h0010_0000);   // generation ahead
        send(ghal_pkg::MODE_CHECK,   32'h000C_0000);   // index far out of range
        send(ghal_pkg::MODE_RELEASE, 32'h0008_0000);   // slot 0 now at generation 2
        send(ghal_pkg::MODE_CHECK,   32'h0008_0000);   // stale after release
        send(ghal_pkg::MODE_RELEASE, 32'h0008_0000);   // stale release rejected
        send(ghal_pkg::MODE_RELEASE, 32'h0010_0000);   // released slot's next generation
        send(ghal_pkg::MODE_RELEASE, 32'h0008_0001);   // live count is zero now
        send(ghal_pkg::MODE_ALLOC,   32'h0000_0000);   // pops slot 0
        send(ghal_pkg::MODE_ALLOC,   32'h0000_0000);   // pops slot 0 again
        send(ghal_pkg::MODE_CHECK,   32'hFFFF_FFFF);
        send(ghal_pkg::MODE_RELEASE, 32'hFFF8_0001);   // top generation, not current
        send(ghal_pkg::MODE_CLEAR,   32'h0000_0000);
        send(ghal_pkg::MODE_CHECK,   32'h0018_0000);   // gone after clear
        send(ghal_pkg::MODE_ALLOC,   32'h0000_0000);
        send(ghal_pkg::MODE_ALLOC,   32'hFFFF_FFFF);
        send(ghal_pkg::MODE_RELEASE, 32'h0008_0001);
        send(ghal_pkg::MODE_RELEASE, 32'h0000_0000);   // generation zero never current
        send(ghal_pkg::MODE_CLEAR,   32'hFFFF_FFFF);

        // phase one: light sender idling, heavy receiver back-pressure
        run_random(RAND_PER_PHASE);
        drain();

        // phase two: the other way round
        send_idle = 68;
        recv_idle = 16;
        run_random(RAND_PER_PHASE);
        drain();

        // phase three: no idling at all
        send_idle = 0;
        recv_idle = 0;
        run_random(RAND_PER_PHASE);

        // fill the table, run into table full, then churn the free stack
        send(ghal_pkg::MODE_CLEAR, $urandom);
        repeat (SLOT_COUNT + 3)
            send(ghal_pkg::MODE_ALLOC, $urandom);
        repeat (8)
            send(ghal_pkg::MODE_CHECK, pick_live());
        send(ghal_pkg::MODE_CHECK, {13'd1, 19'(SLOT_COUNT)});
        repeat (20)
            send(ghal_pkg::MODE_RELEASE, pick_live());
        repeat (25)
            send(ghal_pkg::MODE_ALLOC, $urandom);

        // let everything come back, then watch for stray responses
        drain();
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
